// ===== rtl/rgb_color_correction_core_defines.svh =====
// Assertion macros for the color correction core.
`ifndef RGB_COLOR_CORRECTION_CORE_DEFINES_SVH
`define RGB_COLOR_CORRECTION_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define RGBCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define RGBCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgbcc_pkg.sv =====
`default_nettype none

package rgbcc_pkg;

  localparam int IN_BITS   = 16;
  localparam int OUT_BITS  = 8;
  localparam int RAW_BITS  = 16;

  localparam int GAIN_BITS  = RAW_BITS + 1;
  localparam int GAIN_SHIFT = RAW_BITS + 4;
  localparam int PROD_BITS  = RAW_BITS + GAIN_SHIFT + 1;
  localparam longint unsigned RED_GAIN_MUL  = (17 * (64'd1 << GAIN_SHIFT) + 9) / 10;
  localparam longint unsigned BLUE_GAIN_MUL = (27 * (64'd1 << GAIN_SHIFT) + 19) / 20;

  localparam int FULL_SCALE = 250;
  localparam int LIMIT      = 255;

  localparam int Q_BITS      = 8;
  localparam int Q_IDX_BITS  = $clog2(Q_BITS);
  localparam int Q_PER_STAGE = 2;
  localparam int DIV_STAGES  = Q_BITS / Q_PER_STAGE;
  localparam int NUM_BITS    = GAIN_BITS + Q_BITS;

  localparam int DIV_FIRST  = 2;
  localparam int DIV_LAST   = DIV_FIRST + DIV_STAGES - 1;
  localparam int BACK_FIRST = DIV_LAST + 1;
  localparam int NSTAGES    = BACK_FIRST + 2;

  localparam int DIV5_MUL   = 205;
  localparam int DIV5_SHIFT = 10;

  localparam int CFG_ADDR_BITS = 3;
  localparam int REG_IDX_BITS  = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_LED = 1'b0;

  typedef struct packed {
    logic [IN_BITS-1:0] raw_red;
    logic [IN_BITS-1:0] raw_green;
    logic [IN_BITS-1:0] raw_blue;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red_out;
    logic [OUT_BITS-1:0] green_out;
    logic [OUT_BITS-1:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic                 led;
    logic [GAIN_BITS-1:0] r;
    logic [GAIN_BITS-1:0] g;
    logic [GAIN_BITS-1:0] b;
  } gain_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]  rem_r;
    logic [NUM_BITS-1:0]  rem_g;
    logic [NUM_BITS-1:0]  rem_b;
    logic [Q_BITS-1:0]    q_r;
    logic [Q_BITS-1:0]    q_g;
    logic [Q_BITS-1:0]    q_b;
    logic [GAIN_BITS-1:0] m;
    logic                 scale;
    logic [OUT_BITS-1:0]  keep_r;
    logic [OUT_BITS-1:0]  keep_g;
    logic [OUT_BITS-1:0]  keep_b;
    logic [OUT_BITS-1:0]  mx;
  } div_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] r;
    logic [OUT_BITS-1:0] g;
    logic [OUT_BITS-1:0] b;
    logic [OUT_BITS-1:0] m;
  } lvl_t;

  function automatic logic [OUT_BITS-1:0] div5(input logic [OUT_BITS+1:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(DIV5_MUL);
    return p[DIV5_SHIFT +: OUT_BITS];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbcc_front.sv =====
`default_nettype none

module rgbcc_front (
  input  wire logic               clk,
  input  wire logic [1:0]         en,
  input  wire logic               led,
  input  wire rgbcc_pkg::in_item_t din,
  output rgbcc_pkg::div_t         dout
);
  import rgbcc_pkg::*;

  gain_t s1_r, s1_nxt;
  div_t  s2_r, s2_nxt;

  logic [PROD_BITS-1:0] pr, pb;
  logic [RAW_BITS-1:0]  rr, rg, rb;
  logic [GAIN_BITS-1:0] m;

  always_comb begin
    rr = din.raw_red[RAW_BITS-1:0];
    rg = din.raw_green[RAW_BITS-1:0];
    rb = din.raw_blue[RAW_BITS-1:0];
    pr = PROD_BITS'(rr) * PROD_BITS'(RED_GAIN_MUL);
    pb = PROD_BITS'(rb) * PROD_BITS'(BLUE_GAIN_MUL);
    s1_nxt.led = led;
    s1_nxt.g   = GAIN_BITS'(rg);
    s1_nxt.r   = led ? pr[GAIN_SHIFT +: GAIN_BITS] : GAIN_BITS'(rr);
    s1_nxt.b   = led ? pb[GAIN_SHIFT +: GAIN_BITS] : GAIN_BITS'(rb);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    m = (s1_r.r > s1_r.g) ? s1_r.r : s1_r.g;
    m = (m > s1_r.b) ? m : s1_r.b;
    s2_nxt.rem_r  = NUM_BITS'(s1_r.r) * NUM_BITS'(FULL_SCALE);
    s2_nxt.rem_g  = NUM_BITS'(s1_r.g) * NUM_BITS'(FULL_SCALE);
    s2_nxt.rem_b  = NUM_BITS'(s1_r.b) * NUM_BITS'(FULL_SCALE);
    s2_nxt.q_r    = '0;
    s2_nxt.q_g    = '0;
    s2_nxt.q_b    = '0;
    s2_nxt.m      = m;
    s2_nxt.scale  = (m != '0) && (!s1_r.led || (m > GAIN_BITS'(LIMIT)));
    s2_nxt.keep_r = s1_r.r[OUT_BITS-1:0];
    s2_nxt.keep_g = s1_r.g[OUT_BITS-1:0];
    s2_nxt.keep_b = s1_r.b[OUT_BITS-1:0];
    s2_nxt.mx     = s2_nxt.scale ? OUT_BITS'(FULL_SCALE) : m[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
  end

  assign dout = s2_r;

endmodule

`default_nettype wire

// ===== rtl/rgbcc_div.sv =====
`default_nettype none

module rgbcc_div (
  input  wire logic                              clk,
  input  wire logic [rgbcc_pkg::DIV_STAGES-1:0] en,
  input  wire rgbcc_pkg::div_t                   din,
  output rgbcc_pkg::div_t                        dout
);
  import rgbcc_pkg::*;

  div_t st_r   [DIV_STAGES];
  div_t st_nxt [DIV_STAGES];

  function automatic logic [NUM_BITS:0] div_step(
    input logic [NUM_BITS-1:0]   rem,
    input logic [GAIN_BITS-1:0]  m,
    input logic [Q_IDX_BITS-1:0] sh
  );
    logic [NUM_BITS-1:0] d;
    d = NUM_BITS'(m) << sh;
    if (rem >= d) begin
      return {1'b1, rem - d};
    end
    return {1'b0, rem};
  endfunction

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    div_t cur;

    if (j == 0) begin : g_head
      assign cur = din;
    end else begin : g_tail
      assign cur = st_r[j-1];
    end

    always_comb begin
      logic [NUM_BITS:0]     t;
      logic [Q_IDX_BITS-1:0] shv;
      st_nxt[j] = cur;
      for (int k = 0; k < Q_PER_STAGE; k++) begin
        shv = Q_IDX_BITS'(Q_BITS - 1 - j * Q_PER_STAGE - k);
        t = div_step(st_nxt[j].rem_r, st_nxt[j].m, shv);
        st_nxt[j].q_r[shv] = t[NUM_BITS];
        st_nxt[j].rem_r    = t[NUM_BITS-1:0];
        t = div_step(st_nxt[j].rem_g, st_nxt[j].m, shv);
        st_nxt[j].q_g[shv] = t[NUM_BITS];
        st_nxt[j].rem_g    = t[NUM_BITS-1:0];
        t = div_step(st_nxt[j].rem_b, st_nxt[j].m, shv);
        st_nxt[j].q_b[shv] = t[NUM_BITS];
        st_nxt[j].rem_b    = t[NUM_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign dout = st_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/rgbcc_back.sv =====
`default_nettype none

module rgbcc_back (
  input  wire logic            clk,
  input  wire logic [1:0]      en,
  input  wire rgbcc_pkg::div_t din,
  output rgbcc_pkg::out_item_t dout
);
  import rgbcc_pkg::*;

  lvl_t      s7_r, s7_nxt;
  out_item_t s8_r, s8_nxt;

  logic [OUT_BITS-1:0] r, g, b, m, bh, mn;
  logic                red_max, greenish, bexc;
  logic                mid_r, mid_g, mid_b, low_r, low_g, low_b;
  logic                yellow;

  always_comb begin
    r = din.scale ? din.q_r : din.keep_r;
    g = din.scale ? din.q_g : din.keep_g;
    b = din.scale ? din.q_b : din.keep_b;
    m = din.mx;

    red_max  = (m == r);
    greenish = red_max && (9'(g) >= 9'(b) * 9'd2) && (11'(g) * 11'd5 >= 11'(r));
    bexc     = red_max && (g <= b) && (11'(b) * 11'd5 >= 11'(r));

    low_r = 11'(r) * 11'd5 < 11'(m) * 11'd3;
    low_g = 11'(g) * 11'd5 < 11'(m) * 11'd3;
    low_b = 11'(b) * 11'd5 < 11'(m) * 11'd3;
    mid_r = !low_r && (11'(r) * 11'd5 < 11'(m) * 11'd4);
    mid_g = !low_g && (11'(g) * 11'd5 < 11'(m) * 11'd4);
    mid_b = !low_b && (11'(b) * 11'd5 < 11'(m) * 11'd4);

    bh = greenish ? (b >> 1) : b;

    s7_nxt.m = m;
    s7_nxt.r = r;
    if (mid_r) begin
      s7_nxt.r = div5({1'b0, r, 1'b0});
    end else if (low_r) begin
      s7_nxt.r = div5(10'(r));
    end
    s7_nxt.g = g;
    if (mid_g) begin
      s7_nxt.g = div5({1'b0, g, 1'b0});
    end else if (low_g && !greenish) begin
      s7_nxt.g = div5(10'(g));
    end
    s7_nxt.b = b;
    if (mid_b) begin
      s7_nxt.b = div5({1'b0, b, 1'b0});
    end else if (low_b) begin
      s7_nxt.b = bexc ? bh : div5(10'(bh));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s7_r <= s7_nxt;
    end
  end

  always_comb begin
    mn = (s7_r.r < s7_r.g) ? s7_r.r : s7_r.g;
    mn = (mn < s7_r.b) ? mn : s7_r.b;
    yellow = (s7_r.m == s7_r.g) && (13'(s7_r.r) * 13'd20 >= 13'(s7_r.m) * 13'd17) &&
             (mn == s7_r.b);
    s8_nxt.red_out   = yellow ? s7_r.m : s7_r.r;
    s8_nxt.green_out = s7_r.g;
    s8_nxt.blue_out  = yellow ? div5({1'b0, s7_r.b, 1'b0}) : s7_r.b;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s8_r <= s8_nxt;
    end
  end

  assign dout = s8_r;

endmodule

`default_nettype wire

// ===== rtl/rgb_color_correction_core.sv =====
`default_nettype none

`include "rgb_color_correction_core_defines.svh"

// Color correction core: turns one raw red/green/blue sensor triple into
// corrected 8-bit levels. It takes one item per clock while not stalled. Its
// stages, in order: the LED gains; the maximum and the full-scale products; a
// divider that retires two quotient bits per stage and rescales every channel
// to 250; attenuation; and the yellow fix, which also holds the output
// register. A stall holds the pipeline only as far back as the first empty
// stage. The led_on register (bit 0 at byte address 0 of the register port)
// must be written only while no item is in flight; it resets to 0.
module rgb_color_correction_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire rgbcc_pkg::in_item_t                    in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output rgbcc_pkg::out_item_t                        out_data,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [rgbcc_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  wire logic [31:0]                            pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready
);
  import rgbcc_pkg::*;

  logic                led_r;
  logic [NSTAGES-1:0]  v_r, v_nxt, en;
  logic [REG_IDX_BITS-1:0] reg_idx;
  div_t                front_q, div_q;
  logic                led_wr, quot_ok;

  assign reg_idx = paddr[CFG_ADDR_BITS-1 -: REG_IDX_BITS];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_LED) ? {31'b0, led_r} : 32'b0;
  assign led_wr  = psel && penable && pwrite && pready && (reg_idx == REG_LED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r <= 1'b0;
    end else if (led_wr) begin
      led_r <= pwdata[0];
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[NSTAGES-1] = !v_r[NSTAGES-1] || !out_stall;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < NSTAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTAGES-1];

  rgbcc_front u_front (
    .clk  (clk),
    .en   (en[1:0]),
    .led  (led_r),
    .din  (in_data),
    .dout (front_q)
  );

  rgbcc_div u_div (
    .clk  (clk),
    .en   (en[DIV_LAST:DIV_FIRST]),
    .din  (front_q),
    .dout (div_q)
  );

  rgbcc_back u_back (
    .clk  (clk),
    .en   (en[NSTAGES-1:BACK_FIRST]),
    .din  (div_q),
    .dout (out_data)
  );

  assign quot_ok = (div_q.q_r <= OUT_BITS'(FULL_SCALE)) &&
                   (div_q.q_g <= OUT_BITS'(FULL_SCALE)) &&
                   (div_q.q_b <= OUT_BITS'(FULL_SCALE));

  `RGBCC_ASSERT_IMP(a_no_stall_when_empty, !out_valid, !in_stall, "stall with empty output")
  `RGBCC_ASSERT_IMP(a_quot_range, v_r[DIV_LAST] && div_q.scale, quot_ok, "rescale above full scale")
  `RGBCC_ASSERT_NEXT(a_led_write, led_wr, led_r == $past(pwdata[0]), "led_on write lost")

endmodule

`default_nettype wire

// ===== test/rgb_color_correction_core_tb.sv =====
`timescale 1ns / 1ps

module rgb_color_correction_core_tb;
  import rgbcc_pkg::*;

  class rgb_scoreboard;
    out_item_t   expected_q[$];
    bit          led_on;
    int unsigned n_checked;
    int unsigned n_fail;

    function void write_reg(int unsigned idx, logic [31:0] value);
      if (idx == int'(REG_LED)) begin
        led_on = value[0];
      end
    endfunction

    function out_item_t correct(in_item_t it);
      int unsigned mask;
      int unsigned r, g, b, m, r0, g0, b0, mn;
      bit          red_max, greenish;
      out_item_t   res;
      mask = (32'd1 << RAW_BITS) - 1;
      r = it.raw_red & mask;
      g = it.raw_green & mask;
      b = it.raw_blue & mask;
      if (led_on) begin
        r = r * 17 / 10;
        b = b * 27 / 20;
      end
      m = (r > g) ? r : g;
      m = (m > b) ? m : b;
      if (m != 0 && (!led_on || m > 255)) begin
        r = r * 250 / m;
        g = g * 250 / m;
        b = b * 250 / m;
      end
      m = (r > g) ? r : g;
      m = (m > b) ? m : b;
      r0 = r;
      g0 = g;
      b0 = b;
      red_max  = (m == r0);
      greenish = red_max && g0 >= 2 * b0 && 5 * g0 >= r0;
      if (5 * r < 4 * m && 5 * r >= 3 * m) begin
        r = r * 2 / 5;
      end else if (5 * r < 3 * m) begin
        r = r / 5;
      end
      if (5 * g < 4 * m && 5 * g >= 3 * m) begin
        g = g * 2 / 5;
      end else if (5 * g < 3 * m) begin
        if (!greenish) begin
          g = g / 5;
        end
      end
      if (5 * b < 4 * m && 5 * b >= 3 * m) begin
        b = b * 2 / 5;
      end else if (5 * b < 3 * m) begin
        if (greenish) begin
          b = b / 2;
        end
        if (red_max && g0 <= b0 && 5 * b0 >= r0) begin
          b = b * 5;
        end
        b = b / 5;
      end
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      if (m == g && 20 * r >= 17 * m && mn == b) begin
        r = m;
        b = b * 2 / 5;
      end
      res.red_out   = r[7:0];
      res.green_out = g[7:0];
      res.blue_out  = b[7:0];
      return res;
    endfunction

    function void fail(string msg);
      if (n_fail < 10) begin
        $display("%0t ERROR: %s", $realtime, msg);
      end
      n_fail++;
    endfunction

    function void note_input(in_item_t it);
      expected_q.push_back(correct(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        fail($sformatf("unexpected result r=%0d g=%0d b=%0d",
                       got.red_out, got.green_out, got.blue_out));
        return;
      end
      exp_item = expected_q.pop_front();
      n_checked++;
      if (got.red_out !== exp_item.red_out || got.green_out !== exp_item.green_out ||
          got.blue_out !== exp_item.blue_out) begin
        fail($sformatf("expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       exp_item.red_out, exp_item.green_out, exp_item.blue_out,
                       got.red_out, got.green_out, got.blue_out));
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  rgb_scoreboard sb;
  bit            no_idle;
  int unsigned   n_sent;
  int unsigned   n_led_phases[2];

  rgb_color_correction_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_input(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_side
    int unsigned n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_rgb(input in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic reg_write(input int unsigned idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  function automatic in_item_t rand_rgb();
    int unsigned v[3];
    int unsigned top, lead, mode;
    in_item_t    it;
    mode = $urandom_range(0, 3);
    case (mode)
      0: begin
        foreach (v[i]) v[i] = $urandom_range(0, 65535);
      end
      1: begin
        foreach (v[i]) v[i] = $urandom_range(0, 65535) >> $urandom_range(0, 15);
      end
      2: begin
        top  = ($urandom_range(1, 65535) >> $urandom_range(0, 14)) | 1;
        lead = $urandom_range(0, 2);
        foreach (v[i]) v[i] = (i == lead) ? top : top * $urandom_range(0, 20) / 20;
      end
      default: begin
        foreach (v[i]) v[i] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 300);
      end
    endcase
    it.raw_red   = v[0][15:0];
    it.raw_green = v[1][15:0];
    it.raw_blue  = v[2][15:0];
    return it;
  endfunction

  initial begin : stimulus
    in_item_t    directed[12];
    int unsigned led;
    sb       = new();
    no_idle  = 1'b0;
    n_sent   = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;

    directed[0]  = '{16'd0, 16'd0, 16'd0};
    directed[1]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    directed[2]  = '{16'hFFFF, 16'd0, 16'd0};
    directed[3]  = '{16'd0, 16'hFFFF, 16'd0};
    directed[4]  = '{16'd0, 16'd0, 16'hFFFF};
    directed[5]  = '{16'd1000, 16'd300, 16'd100};
    directed[6]  = '{16'd1000, 16'd200, 16'd400};
    directed[7]  = '{16'd900, 16'd1000, 16'd100};
    directed[8]  = '{16'd700, 16'd1000, 16'd650};
    directed[9]  = '{16'd150, 16'd255, 16'd189};
    directed[10] = '{16'd151, 16'd100, 16'd190};
    directed[11] = '{16'h5555, 16'hAAAA, 16'h00FF};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_rgb(directed[i]);
    drain();
    n_led_phases[0]++;
    reg_write(0, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});
    foreach (directed[i]) send_rgb(directed[i]);
    drain();
    n_led_phases[1]++;
    reg_write(1, $urandom);

    for (int p = 0; p < 9; p++) begin
      led = (p + 1) % 2;
      reg_write(0, {31'($urandom_range(0, 32'h7FFF_FFFF)), led[0]});
      n_led_phases[led]++;
      for (int k = 0; k < 48; k++) begin
        if (k % 16 == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
        end
        send_rgb(rand_rgb());
      end
      drain();
    end

    $display("Sent %0d items, checked %0d results over %0d LED-off and %0d LED-on phases.",
             n_sent, sb.n_checked, n_led_phases[0], n_led_phases[1]);
    $display("Failures: %0d, results still pending: %0d.", sb.n_fail, sb.pending());
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
